// ===== rtl/rgt_pkg.sv =====
// ----------------------------------------------------------------------------
// rgt_pkg
// Shared constants and types of the range grid triangulation block.
// ----------------------------------------------------------------------------
`default_nettype none

package rgt_pkg;

   // default sizes handed to the top level parameters
   localparam int DEFAULT_MAX_WIDTH  = 1024;
   localparam int DEFAULT_MAX_HEIGHT = 1024;
   localparam int DEFAULT_COORD_BITS = 24;

   // fixed field widths
   localparam int IDX_BITS       = 20;
   localparam int DIM_BITS       = 11;
   localparam int LIMIT_BITS     = 52;
   localparam int CSR_INDEX_BITS = 2;

   // a coordinate difference at or above 2^DIFF_BITS always fails the limit
   localparam int DIFF_BITS = 26;

   localparam int MIN_DIM = 2;

   // result queue
   localparam int QUEUE_DEPTH = 16;

   // register reset values
   localparam logic [DIM_BITS-1:0]   RESET_IMAGE_WIDTH  = 11'd640;
   localparam logic [DIM_BITS-1:0]   RESET_IMAGE_HEIGHT = 11'd480;
   localparam logic [LIMIT_BITS-1:0] RESET_EDGE_LIMIT   = 52'd429497;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_EDGE_LIMIT   = 2'd2
   } csr_index_type;

   // vertex indices of the four quad corners
   typedef struct packed {
      logic [IDX_BITS-1:0] top_left;
      logic [IDX_BITS-1:0] top_right;
      logic [IDX_BITS-1:0] bottom_left;
      logic [IDX_BITS-1:0] bottom_right;
   } quad_idx_type;

   typedef struct packed {
      quad_idx_type idx;
      logic         first_ok;
      logic         second_ok;
   } queue_entry_type;

endpackage

`default_nettype wire

// ===== rtl/rgt_edge_check.sv =====
// ----------------------------------------------------------------------------
// rgt_edge_check
// Three-stage pipelined check that the squared distance between two points
// is strictly below a limit: abs difference, squares, sum and compare.
// ----------------------------------------------------------------------------
`default_nettype none

module rgt_edge_check #(
   parameter int COORD_BITS = rgt_pkg::DEFAULT_COORD_BITS
) (
   input  wire logic                            clock,
   input  wire logic [3*COORD_BITS-1:0]         p_pos,
   input  wire logic [3*COORD_BITS-1:0]         q_pos,
   input  wire logic [rgt_pkg::LIMIT_BITS-1:0]  limit,
   output logic                                 edge_short
);

   localparam int DW   = COORD_BITS + 1;
   localparam int SQW  = 2 * rgt_pkg::DIFF_BITS;
   localparam int SUMW = SQW + 2;

   logic [DW-1:0]                  diff [3];
   logic [DW-1:0]                  mag [3];
   logic [2:0]                     big;
   logic [rgt_pkg::DIFF_BITS-1:0]  dist_ff [3];
   logic                           big_a_ff;
   logic [SQW-1:0]                 sq_ff [3];
   logic                           big_b_ff;
   logic [SUMW-1:0]                sum;
   logic                           edge_short_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         diff[k] = {p_pos[k*COORD_BITS+COORD_BITS-1], p_pos[k*COORD_BITS +: COORD_BITS]}
                 - {q_pos[k*COORD_BITS+COORD_BITS-1], q_pos[k*COORD_BITS +: COORD_BITS]};
         mag[k]  = diff[k][DW-1] ? (~diff[k] + 1'b1) : diff[k];
         big[k]  = |(mag[k] >> rgt_pkg::DIFF_BITS);
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         dist_ff[k] <= rgt_pkg::DIFF_BITS'(mag[k]);
         sq_ff[k]   <= dist_ff[k] * dist_ff[k];
      end
      big_a_ff <= |big;
      big_b_ff <= big_a_ff;
   end

   assign sum = SUMW'(sq_ff[0]) + SUMW'(sq_ff[1]) + SUMW'(sq_ff[2]);

   always_ff @(posedge clock) begin
      edge_short_ff <= !big_b_ff && (sum < SUMW'(limit));
   end

   assign edge_short = edge_short_ff;

endmodule

`default_nettype wire

// ===== rtl/range_grid_triangulation.sv =====
// ----------------------------------------------------------------------------
// range_grid_triangulation
// Builds triangles from a raster stream of range image vertices.
// Throughput: one vertex per cycle while req_stall is low; line store read and
// written on each accept. The output port moves one triangle per cycle while
// rsp_stall is low; a 16-entry result queue absorbs bursts, and req_stall rises
// when queue plus in-flight vertices could overflow. Reset clears counters, stage
// valid bits and queue and loads register defaults; line store not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module range_grid_triangulation #(
   parameter int MAX_WIDTH  = rgt_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = rgt_pkg::DEFAULT_MAX_HEIGHT,
   parameter int COORD_BITS = rgt_pkg::DEFAULT_COORD_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_vertex_valid,
   input  wire logic signed [COORD_BITS-1:0]        req_pos_x,
   input  wire logic signed [COORD_BITS-1:0]        req_pos_y,
   input  wire logic signed [COORD_BITS-1:0]        req_pos_z,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [rgt_pkg::IDX_BITS-1:0]             rsp_corner_a,
   output logic [rgt_pkg::IDX_BITS-1:0]             rsp_corner_b,
   output logic [rgt_pkg::IDX_BITS-1:0]             rsp_corner_c,
   output logic                                     rsp_last_face,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [rgt_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [rgt_pkg::LIMIT_BITS-1:0]      csr_data
);

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int RW  = $clog2(MAX_HEIGHT);
   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int HW  = $clog2(MAX_HEIGHT + 1);
   localparam int PW  = 3 * COORD_BITS;
   localparam int VW  = PW + 1;
   localparam int IW  = rgt_pkg::IDX_BITS;
   localparam int QW  = $clog2(rgt_pkg::QUEUE_DEPTH);
   localparam int QCW = $clog2(rgt_pkg::QUEUE_DEPTH + 1);

   // ---------------------------------------------------------------- config
   logic [rgt_pkg::DIM_BITS-1:0]    image_width_ff;
   logic [rgt_pkg::DIM_BITS-1:0]    image_height_ff;
   logic [rgt_pkg::LIMIT_BITS-1:0]  edge_limit_ff;
   logic [WW-1:0]                   width_eff;
   logic [HW-1:0]                   height_eff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= rgt_pkg::RESET_IMAGE_WIDTH;
         image_height_ff <= rgt_pkg::RESET_IMAGE_HEIGHT;
         edge_limit_ff   <= rgt_pkg::RESET_EDGE_LIMIT;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            rgt_pkg::CSR_IMAGE_WIDTH:  image_width_ff  <= rgt_pkg::DIM_BITS'(csr_data);
            rgt_pkg::CSR_IMAGE_HEIGHT: image_height_ff <= rgt_pkg::DIM_BITS'(csr_data);
            rgt_pkg::CSR_EDGE_LIMIT:   edge_limit_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (32'(image_width_ff) < 32'(rgt_pkg::MIN_DIM)) begin
         width_eff = WW'(rgt_pkg::MIN_DIM);
      end else if (32'(image_width_ff) > 32'(MAX_WIDTH)) begin
         width_eff = WW'(MAX_WIDTH);
      end else begin
         width_eff = WW'(image_width_ff);
      end
      if (32'(image_height_ff) < 32'(rgt_pkg::MIN_DIM)) begin
         height_eff = HW'(rgt_pkg::MIN_DIM);
      end else if (32'(image_height_ff) > 32'(MAX_HEIGHT)) begin
         height_eff = HW'(MAX_HEIGHT);
      end else begin
         height_eff = HW'(image_height_ff);
      end
   end

   // ---------------------------------------------------------------- counters
   logic           accept;
   logic [CW-1:0]  col_ff, col_in;
   logic [RW-1:0]  row_ff, row_in;
   logic [CW:0]    col_inc;
   logic [RW:0]    row_inc;

   assign accept  = req_valid && !req_stall;
   assign col_inc = {1'b0, col_ff} + 1'b1;
   assign row_inc = {1'b0, row_ff} + 1'b1;

   always_comb begin
      if (32'(col_inc) >= 32'(width_eff)) begin
         col_in = '0;
         row_in = (32'(row_inc) >= 32'(height_eff)) ? '0 : RW'(row_inc);
      end else begin
         col_in = CW'(col_inc);
         row_in = (32'(row_ff) >= 32'(height_eff)) ? '0 : row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ---------------------------------------------------------------- line store
   logic [VW-1:0]  row_store_mem [MAX_WIDTH];
   logic [VW-1:0]  cur_word;
   logic [VW-1:0]  left_ff;
   logic [CW-1:0]  tl_addr;
   logic [CW-1:0]  wr_addr;
   logic [VW-1:0]  tl_ff;
   logic [VW-1:0]  tr_ff;

   assign cur_word = {req_vertex_valid, req_pos_x, req_pos_y, req_pos_z};
   assign tl_addr  = (col_ff == '0) ? '0 : col_ff - 1'b1;
   // at column 0 the last vertex of the row before goes to the row end
   assign wr_addr  = (col_ff == '0) ? CW'(width_eff - 1'b1) : col_ff - 1'b1;

   // reads return the previous row; the write of the same edge lands after
   always_ff @(posedge clock) begin
      if (accept) begin
         tl_ff                  <= row_store_mem[tl_addr];
         tr_ff                  <= row_store_mem[col_ff];
         row_store_mem[wr_addr] <= left_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         left_ff <= cur_word;
      end
   end

   // ---------------------------------------------------------------- stage 1
   logic           v1_ff;
   logic           quad_s1_ff;
   logic [VW-1:0]  bl_s1_ff;
   logic [VW-1:0]  cur_s1_ff;
   logic [CW-1:0]  col_s1_ff;
   logic [RW-1:0]  row_s1_ff;
   logic [WW-1:0]  width_s1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         quad_s1_ff  <= (col_ff != '0) && (row_ff != '0);
         bl_s1_ff    <= left_ff;
         cur_s1_ff   <= cur_word;
         col_s1_ff   <= col_ff;
         row_s1_ff   <= row_ff;
         width_s1_ff <= width_eff;
      end
   end

   // edge checks, results line up with stage 4
   logic e_tl_bl, e_bl_tr, e_tr_tl, e_bl_cur, e_cur_tr;

   rgt_edge_check #(.COORD_BITS(COORD_BITS)) u_edge_tl_bl (
      .clock(clock), .p_pos(tl_ff[PW-1:0]), .q_pos(bl_s1_ff[PW-1:0]),
      .limit(edge_limit_ff), .edge_short(e_tl_bl)
   );
   rgt_edge_check #(.COORD_BITS(COORD_BITS)) u_edge_bl_tr (
      .clock(clock), .p_pos(bl_s1_ff[PW-1:0]), .q_pos(tr_ff[PW-1:0]),
      .limit(edge_limit_ff), .edge_short(e_bl_tr)
   );
   rgt_edge_check #(.COORD_BITS(COORD_BITS)) u_edge_tr_tl (
      .clock(clock), .p_pos(tr_ff[PW-1:0]), .q_pos(tl_ff[PW-1:0]),
      .limit(edge_limit_ff), .edge_short(e_tr_tl)
   );
   rgt_edge_check #(.COORD_BITS(COORD_BITS)) u_edge_bl_cur (
      .clock(clock), .p_pos(bl_s1_ff[PW-1:0]), .q_pos(cur_s1_ff[PW-1:0]),
      .limit(edge_limit_ff), .edge_short(e_bl_cur)
   );
   rgt_edge_check #(.COORD_BITS(COORD_BITS)) u_edge_cur_tr (
      .clock(clock), .p_pos(cur_s1_ff[PW-1:0]), .q_pos(tr_ff[PW-1:0]),
      .limit(edge_limit_ff), .edge_short(e_cur_tr)
   );

   // ---------------------------------------------------------------- stage 2
   logic              v2_ff;
   logic              quad_s2_ff;
   logic [3:0]        vld_s2_ff;
   logic [CW-1:0]     col_s2_ff;
   logic [WW-1:0]     width_s2_ff;
   logic [IW-1:0]     base_s2_ff;
   logic [RW-1:0]     row_above;
   logic [RW+WW-1:0]  base_full;

   assign row_above = row_s1_ff - 1'b1;
   assign base_full = row_above * width_s1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
   end

   // corner valid bits: top-left, bottom-left, top-right, current
   always_ff @(posedge clock) begin
      quad_s2_ff  <= quad_s1_ff;
      vld_s2_ff   <= {tl_ff[VW-1], bl_s1_ff[VW-1], tr_ff[VW-1], cur_s1_ff[VW-1]};
      col_s2_ff   <= col_s1_ff;
      width_s2_ff <= width_s1_ff;
      base_s2_ff  <= IW'(base_full);
   end

   // ---------------------------------------------------------------- stage 3
   logic                   v3_ff;
   logic                   quad_s3_ff;
   logic [3:0]             vld_s3_ff;
   rgt_pkg::quad_idx_type  idx_s3_ff;
   rgt_pkg::quad_idx_type  idx_calc;
   logic [IW-1:0]          top_right_idx;
   logic [IW-1:0]          bottom_right_idx;

   assign top_right_idx    = base_s2_ff + IW'(col_s2_ff);
   assign bottom_right_idx = base_s2_ff + IW'(width_s2_ff) + IW'(col_s2_ff);

   always_comb begin
      idx_calc.top_left     = top_right_idx - 1'b1;
      idx_calc.top_right    = top_right_idx;
      idx_calc.bottom_left  = bottom_right_idx - 1'b1;
      idx_calc.bottom_right = bottom_right_idx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      quad_s3_ff <= quad_s2_ff;
      vld_s3_ff  <= vld_s2_ff;
      idx_s3_ff  <= idx_calc;
   end

   // ---------------------------------------------------------------- stage 4
   logic                   v4_ff;
   logic                   quad_s4_ff;
   logic [3:0]             vld_s4_ff;
   rgt_pkg::quad_idx_type  idx_s4_ff;
   logic                   first_ok;
   logic                   second_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      quad_s4_ff <= quad_s3_ff;
      vld_s4_ff  <= vld_s3_ff;
      idx_s4_ff  <= idx_s3_ff;
   end

   assign first_ok  = quad_s4_ff && vld_s4_ff[3] && vld_s4_ff[2] && vld_s4_ff[1]
                      && e_tl_bl && e_bl_tr && e_tr_tl;
   assign second_ok = quad_s4_ff && vld_s4_ff[2] && vld_s4_ff[1] && vld_s4_ff[0]
                      && e_bl_tr && e_bl_cur && e_cur_tr;

   // ---------------------------------------------------------------- result queue
   rgt_pkg::queue_entry_type  queue_mem [rgt_pkg::QUEUE_DEPTH];
   rgt_pkg::queue_entry_type  push_entry;
   rgt_pkg::queue_entry_type  head;
   logic [QW-1:0]             wr_ptr_ff;
   logic [QW-1:0]             rd_ptr_ff;
   logic [QCW-1:0]            count_ff;
   logic                      phase_ff;
   logic                      push;
   logic                      pop;
   logic                      rsp_accept;
   logic                      show_second;
   logic [QCW:0]              occupancy;

   assign push_entry.idx       = idx_s4_ff;
   assign push_entry.first_ok  = first_ok;
   assign push_entry.second_ok = second_ok;

   assign push = v4_ff && (first_ok || second_ok);

   always_ff @(posedge clock) begin
      if (push) begin
         queue_mem[wr_ptr_ff] <= push_entry;
      end
   end

   assign head        = queue_mem[rd_ptr_ff];
   assign rsp_valid   = (count_ff != '0);
   assign rsp_accept  = rsp_valid && !rsp_stall;
   assign show_second = phase_ff || !head.first_ok;

   assign rsp_corner_a  = show_second ? head.idx.top_right    : head.idx.top_left;
   assign rsp_corner_b  = head.idx.bottom_left;
   assign rsp_corner_c  = show_second ? head.idx.bottom_right : head.idx.top_right;
   assign rsp_last_face = show_second || !head.second_ok;

   assign pop = rsp_accept && rsp_last_face;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         phase_ff  <= 1'b0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
         if (rsp_accept) begin
            phase_ff <= !rsp_last_face;
         end
      end
   end

   // every vertex in flight may still need a queue entry
   assign occupancy = {1'b0, count_ff} + (QCW+1)'(v1_ff) + (QCW+1)'(v2_ff)
                    + (QCW+1)'(v3_ff) + (QCW+1)'(v4_ff);
   assign req_stall = (32'(occupancy) >= 32'(rgt_pkg::QUEUE_DEPTH));

endmodule

`default_nettype wire

// ===== rtl/rgt_checker.sv =====
// ----------------------------------------------------------------------------
// rgt_checker
// Port-level checks of the range grid triangulation block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module rgt_checker (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_stall,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_stall,
   input wire logic [rgt_pkg::IDX_BITS-1:0]  rsp_corner_a,
   input wire logic [rgt_pkg::IDX_BITS-1:0]  rsp_corner_b,
   input wire logic [rgt_pkg::IDX_BITS-1:0]  rsp_corner_c,
   input wire logic                     rsp_last_face
);

   // nothing left over after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("result pending or input stalled right after reset");

   // a first triangle is always followed by the second of the same quad
   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_face |=> rsp_valid)
      else $error("second triangle of a quad missing");

   // the two triangles of a quad share the diagonal
   a_pair_shares_edge: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_face |=>
         rsp_corner_a == $past(rsp_corner_c) && rsp_corner_b == $past(rsp_corner_b))
      else $error("triangle pair does not share the diagonal");

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_corner_a)
         && $stable(rsp_corner_b) && $stable(rsp_corner_c) && $stable(rsp_last_face))
      else $error("stalled result word changed");

endmodule

bind range_grid_triangulation rgt_checker u_rgt_checker (
   .clock(clock),
   .reset(reset),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_corner_a(rsp_corner_a),
   .rsp_corner_b(rsp_corner_b),
   .rsp_corner_c(rsp_corner_c),
   .rsp_last_face(rsp_last_face)
);

`default_nettype wire

// ===== tb/range_grid_triangulation_test.sv =====
// ----------------------------------------------------------------------------
// range_grid_triangulation_test
// Streams range image vertices into the triangulation block and checks every
// triangle it emits against a predictor that models the line store, the left
// vertex and the row and column counters. It walks several grid sizes and edge
// limits, including the clamped, mid-frame and extreme ones, under random
// sender and receiver gaps.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module range_grid_triangulation_test;
   import rgt_pkg::*;

   localparam int COORD = DEFAULT_COORD_BITS;
   localparam int MAX_W = DEFAULT_MAX_WIDTH;
   localparam int MAX_H = DEFAULT_MAX_HEIGHT;
   localparam int COORD_MAX = 8388607;
   localparam int COORD_MIN = -8388608;
   localparam logic [LIMIT_BITS-1:0] LIMIT_MAX = '1;

   typedef struct {
      logic                    vld;
      logic signed [COORD-1:0] x;
      logic signed [COORD-1:0] y;
      logic signed [COORD-1:0] z;
   } vertex_word_type;

   typedef struct {
      bit                      known;
      logic                    vld;
      logic signed [COORD-1:0] x;
      logic signed [COORD-1:0] y;
      logic signed [COORD-1:0] z;
   } stored_vertex_type;

   typedef struct {
      logic [IDX_BITS-1:0] corner_a;
      logic [IDX_BITS-1:0] corner_b;
      logic [IDX_BITS-1:0] corner_c;
      logic                last_face;
   } face_word_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   wire                       req_stall;
   logic                      req_vertex_valid = 1'b0;
   logic signed [COORD-1:0]   req_pos_x = '0;
   logic signed [COORD-1:0]   req_pos_y = '0;
   logic signed [COORD-1:0]   req_pos_z = '0;
   wire                       rsp_valid;
   logic                      rsp_stall = 1'b0;
   wire [IDX_BITS-1:0]        rsp_corner_a;
   wire [IDX_BITS-1:0]        rsp_corner_b;
   wire [IDX_BITS-1:0]        rsp_corner_c;
   wire                       rsp_last_face;
   logic                      csr_valid = 1'b0;
   wire                       csr_ready;
   csr_index_type             csr_index = CSR_IMAGE_WIDTH;
   logic [LIMIT_BITS-1:0]     csr_data = '0;

   // register copies, updated on each accepted write
   logic [DIM_BITS-1:0]       width_raw  = RESET_IMAGE_WIDTH;
   logic [DIM_BITS-1:0]       height_raw = RESET_IMAGE_HEIGHT;
   logic [LIMIT_BITS-1:0]     limit_sq   = RESET_EDGE_LIMIT;

   // predictor state
   stored_vertex_type         line_store [MAX_W];
   stored_vertex_type         left_vertex;
   int                        pred_col = 0;
   int                        pred_row = 0;
   face_word_type             expected_faces [$];

   // stimulus state
   vertex_word_type           pending_vertices [$];
   int                        gen_col = 0;
   int                        gen_row = 0;
   int                        grid_step = 256;
   int                        grid_noise = 0;
   int                        x_base = 0;
   int                        y_base = 0;
   int                        z_base = 0;
   int                        send_idle_pct = 0;
   int                        recv_idle_pct = 0;
   bit                        vertex_taken = 1'b0;
   int                        mismatches = 0;

   range_grid_triangulation i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_vertex_valid (req_vertex_valid),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pos_z        (req_pos_z),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_corner_a     (rsp_corner_a),
      .rsp_corner_b     (rsp_corner_b),
      .rsp_corner_c     (rsp_corner_c),
      .rsp_last_face    (rsp_last_face),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #1_000_000;
      $display("Mismatches found");
      $finish;
   end

   function automatic int eff_dim(logic [DIM_BITS-1:0] raw, int top);
      if (raw < MIN_DIM) return MIN_DIM;
      if (raw > top) return top;
      return int'(raw);
   endfunction

   task automatic step_position(inout int col, inout int row, input int w, input int h);
      col++;
      if (col >= w) begin
         col = 0;
         row++;
         if (row >= h) row = 0;
      end else if (row >= h) begin
         row = 0;
      end
   endtask

   function automatic bit span_short(stored_vertex_type p, stored_vertex_type q);
      longint dx, dy, dz;
      dx = longint'(p.x) - longint'(q.x);
      dy = longint'(p.y) - longint'(q.y);
      dz = longint'(p.z) - longint'(q.z);
      return (dx * dx + dy * dy + dz * dz) < longint'(limit_sq);
   endfunction

   function automatic bit face_ok(stored_vertex_type p, stored_vertex_type q,
                                  stored_vertex_type s);
      if (!(p.vld && q.vld && s.vld)) return 1'b0;
      return span_short(p, q) && span_short(q, s) && span_short(s, p);
   endfunction

   function automatic void add_face(face_word_type f);
      expected_faces = {expected_faces, f};
   endfunction

   task automatic predict_faces(input logic vld, input logic signed [COORD-1:0] x,
                                input logic signed [COORD-1:0] y,
                                input logic signed [COORD-1:0] z);
      stored_vertex_type   cur, tl, tr;
      int                  w, h, c, r;
      bit                  first_ok;
      logic [IDX_BITS-1:0] i_tl, i_tr, i_bl, i_br;
      w = eff_dim(width_raw, MAX_W);
      h = eff_dim(height_raw, MAX_H);
      c = pred_col % MAX_W;
      r = pred_row;
      cur = '{known: 1'b1, vld: vld, x: x, y: y, z: z};
      if (c == 0) begin
         line_store[w - 1] = left_vertex;
      end else begin
         tl = line_store[c - 1];
         tr = line_store[c];
         if (r >= 1) begin
            i_tl = IDX_BITS'((r - 1) * w + c - 1);
            i_tr = IDX_BITS'((r - 1) * w + c);
            i_bl = IDX_BITS'(r * w + c - 1);
            i_br = IDX_BITS'(r * w + c);
            first_ok = face_ok(tl, left_vertex, tr);
            if (first_ok)
               add_face('{i_tl, i_bl, i_tr, 1'b1});
            if (face_ok(tr, left_vertex, cur)) begin
               if (first_ok) expected_faces[$].last_face = 1'b0;
               add_face('{i_tr, i_bl, i_br, 1'b1});
            end
         end
         line_store[c - 1] = left_vertex;
      end
      left_vertex = cur;
      step_position(pred_col, pred_row, w, h);
   endtask

   function automatic void check_field(string name, logic [IDX_BITS-1:0] want,
                                       logic [IDX_BITS-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // sender: a word stays put until taken
   always @(negedge clock) begin : driver
      vertex_word_type next_word;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || vertex_taken) begin
         if (pending_vertices.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
            next_word = pending_vertices.pop_front();
            req_valid <= 1'b1;
            req_vertex_valid <= next_word.vld;
            req_pos_x <= next_word.x;
            req_pos_y <= next_word.y;
            req_pos_z <= next_word.z;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99, 0) < recv_idle_pct);
   end

   always @(posedge clock) begin : monitor
      face_word_type want;
      vertex_taken = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            vertex_taken = 1'b1;
            predict_faces(req_vertex_valid, req_pos_x, req_pos_y, req_pos_z);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_faces.size() == 0) begin
               $error("triangle %0d %0d %0d with none expected",
                      rsp_corner_a, rsp_corner_b, rsp_corner_c);
               mismatches++;
            end else begin
               want = expected_faces.pop_front();
               check_field("corner_a", want.corner_a, rsp_corner_a);
               check_field("corner_b", want.corner_b, rsp_corner_b);
               check_field("corner_c", want.corner_c, rsp_corner_c);
               check_field("last_face", IDX_BITS'(want.last_face), IDX_BITS'(rsp_last_face));
            end
         end
      end
   end

   task automatic push_vertex(logic vld, int x, int y, int z);
      vertex_word_type v;
      v = '{vld: vld, x: COORD'(x), y: COORD'(y), z: COORD'(z)};
      pending_vertices = {pending_vertices, v};
      step_position(gen_col, gen_row, eff_dim(width_raw, MAX_W), eff_dim(height_raw, MAX_H));
   endtask

   function automatic int jitter();
      return int'($urandom_range(2 * grid_noise, 0)) - grid_noise;
   endfunction

   task automatic push_grid_vertex(logic vld);
      push_vertex(vld, x_base + gen_col * grid_step + jitter(),
                  y_base + gen_row * grid_step + jitter(), z_base + jitter());
   endtask

   // mostly a noisy surface, some invalid markers and some stray points
   task automatic push_surface_vertex();
      int roll;
      roll = $urandom_range(99, 0);
      if (roll < 8)
         push_vertex(1'b0, $urandom(), $urandom(), $urandom());
      else if (roll < 18)
         push_vertex(1'b1, $urandom(), $urandom(), $urandom());
      else
         push_grid_vertex($urandom_range(99, 0) >= 4);
   endtask

   task automatic pick_surface(int step, int noise);
      grid_step = step;
      grid_noise = noise;
      x_base = int'($urandom_range(1 << 22, 0)) - (1 << 21);
      y_base = int'($urandom_range(1 << 22, 0)) - (1 << 21);
      z_base = int'($urandom_range(1 << 22, 0)) - (1 << 21);
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (pending_vertices.size() != 0 || req_valid || expected_faces.size() != 0);
      // vertices that make no triangle may still be in flight
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [LIMIT_BITS-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_IMAGE_WIDTH:  width_raw = value[DIM_BITS-1:0];
         CSR_IMAGE_HEIGHT: height_raw = value[DIM_BITS-1:0];
         CSR_EDGE_LIMIT:   limit_sq = value;
         default: ;
      endcase
   endtask

   // a width change must not make the block read store entries never written
   function automatic bit width_change_safe(int new_w);
      int top;
      if (pred_col == 0 && pred_row == 0) return 1'b1;
      top = (new_w - 1 > pred_col) ? new_w - 1 : pred_col;
      for (int k = 0; k <= top; k++)
         if (!line_store[k].known) return 1'b0;
      return 1'b1;
   endfunction

   task automatic configure(int w_raw, int h_raw, logic [LIMIT_BITS-1:0] limit);
      int new_w;
      new_w = eff_dim(DIM_BITS'(w_raw), MAX_W);
      wait_drained();
      gen_col = pred_col;
      gen_row = pred_row;
      if (new_w != eff_dim(width_raw, MAX_W) && !width_change_safe(new_w)) begin
         // shorten the frame and run it out before the width moves
         write_reg(CSR_IMAGE_HEIGHT, LIMIT_BITS'(MIN_DIM));
         @(negedge clock) csr_valid <= 1'b0;
         do push_surface_vertex();
         while (gen_col != 0 || gen_row != 0);
         wait_drained();
      end
      write_reg(CSR_IMAGE_WIDTH, LIMIT_BITS'(w_raw));
      write_reg(CSR_IMAGE_HEIGHT, LIMIT_BITS'(h_raw));
      write_reg(CSR_EDGE_LIMIT, limit);
      @(negedge clock) csr_valid <= 1'b0;
      gen_col = pred_col;
      gen_row = pred_row;
   endtask

   task automatic run_surface(int count);
      repeat (count) push_surface_vertex();
   endtask

   initial begin
      send_idle_pct = 18;
      recv_idle_pct = 62;
      repeat (3) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // coordinate extremes, one invalid corner in the second quad
      configure(3, 2, LIMIT_MAX);
      push_vertex(1'b1, COORD_MAX, COORD_MIN, COORD_MAX);
      push_vertex(1'b1, COORD_MIN, COORD_MAX, COORD_MIN);
      push_vertex(1'b1, COORD_MAX, COORD_MAX, COORD_MIN);
      push_vertex(1'b1, COORD_MIN, COORD_MIN, COORD_MAX);
      push_vertex(1'b1, COORD_MAX, COORD_MIN, COORD_MIN);
      push_vertex(1'b0, COORD_MIN, COORD_MAX, COORD_MAX);

      // diagonal squared length exactly at the limit, then one above
      pick_surface(256, 0);
      configure(3, 2, LIMIT_BITS'(131072));
      repeat (6) push_grid_vertex(1'b1);
      configure(3, 2, LIMIT_BITS'(131073));
      repeat (6) push_grid_vertex(1'b1);

      // out of range sizes clamp
      configure(0, 2047, LIMIT_BITS'(131073));
      repeat (4) push_grid_vertex(1'b1);

      pick_surface(256, 64);
      configure(5, 4, LIMIT_BITS'(300000));
      run_surface(150);
      pick_surface(256, 96);
      configure(1, 0, LIMIT_BITS'($urandom_range(4 * 256 * 256, 256 * 256)));
      run_surface(120);
      pick_surface(256, 200);
      configure(7, 1024, LIMIT_MAX);
      run_surface(120);

      send_idle_pct = 62;
      recv_idle_pct = 18;
      pick_surface(256, 64);
      configure(2047, 1, RESET_EDGE_LIMIT);
      run_surface(1040);
      // shrinks while the column is past the new width
      configure(6, 3, '0);
      run_surface(60);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      pick_surface(64, 48);
      configure(9, 5, LIMIT_BITS'($urandom_range(4 * 64 * 64, 64 * 64)));
      run_surface(200);
      pick_surface(256, 64);
      configure(4, 2, LIMIT_BITS'(200000));
      run_surface(150);
      configure(12, 6, LIMIT_BITS'($urandom_range(4 * 256 * 256, 256 * 256)));
      run_surface(150);

      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_faces.size() == 0) begin
         $display("No mismatches found");
      end else begin
         if (expected_faces.size() != 0)
            $error("%0d triangles never arrived", expected_faces.size());
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== range_grid_triangulation.f =====
rtl/rgt_pkg.sv
rtl/rgt_edge_check.sv
rtl/range_grid_triangulation.sv
rtl/rgt_checker.sv
tb/range_grid_triangulation_test.sv
